### rtl/core/ltt_pkg.sv
package ltt_pkg;

	localparam int W = 32;
	localparam int F = 16;

	localparam int CFG_N     = 8;
	localparam int CFG_IDX_W = 3;

	localparam int EPS_T      = ((1 << F) + 500000) / 1000000;
	localparam int DT_MIN_RAW = ((1 << F) + 5000) / 10000;
	localparam int DT_MIN     = (DT_MIN_RAW == 0) ? 1 : DT_MIN_RAW;

	localparam logic [W-2:0] WMAX31 = {(W-1){1'b1}};
	localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
	localparam logic [16:0] PROG_ONE = 17'h10000;

	localparam logic [CFG_IDX_W-1:0] REG_START_X  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_Y  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_Z  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FINISH_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FINISH_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FINISH_Z = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL    = 3'd7;

	typedef enum logic [1:0] {
		FUNC_START  = 2'd0,
		FUNC_STEP   = 2'd1,
		FUNC_CANCEL = 2'd2,
		FUNC_SPARE  = 2'd3
	} func_t;

	typedef enum logic [5:0] {
		OP_NONE, OP_LATCH, OP_SQ, OP_SUM, OP_SQRT_SUM, OP_LEN, OP_ZERO,
		OP_DIV_DIR, OP_DIR, OP_DIV_TA, OP_TA, OP_M_A_TA, OP_M_P_TA, OP_DA,
		OP_DIV_CT, OP_CT, OP_MT, OP_M_A_L, OP_SQRT_VP, OP_DIV_AT, OP_AT,
		OP_STEP, OP_CANCEL, OP_SPARE, OP_S1, OP_S2, OP_S3, OP_S4, OP_S5,
		OP_P1, OP_P2, OP_DIV_PR, OP_PR, OP_EMIT
	} dp_op_t;

	typedef enum logic [5:0] {
		ST_IDLE, ST_LATCH, ST_SQ, ST_SUM, ST_SQRT_GO, ST_SQRT_WAIT, ST_CHECK,
		ST_ZERO, ST_DIR_GO, ST_DIR_WAIT, ST_TA_GO, ST_TA_WAIT, ST_DA_M1,
		ST_DA_M2, ST_DA_PUT, ST_DECIDE, ST_CT_GO, ST_CT_WAIT, ST_MT,
		ST_VP_MUL, ST_VP_GO, ST_VP_WAIT, ST_AT_GO, ST_AT_WAIT, ST_STEP,
		ST_CANCEL, ST_SPARE, ST_S1, ST_S2, ST_S3, ST_S4, ST_S5, ST_P1, ST_P2,
		ST_PR_GO, ST_PR_WAIT, ST_EMIT
	} ctrl_state_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] axis;
		logic       take;
	} ltt_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic sqrt_busy;
		logic degen;
		logic short_move;
	} ltt_sts_t;

	// Q-format product back to word scale, saturated, for non-negative operands
	function automatic logic [W-2:0] mq_sat(input logic [2*W-1:0] p);
		logic [W-2:0] r;
		if (|p[2*W-1:W-1+F])
			r = WMAX31;
		else
			r = p[W-2+F:F];
		return r;
	endfunction

	function automatic logic signed [W-1:0] sat_w(input logic signed [W:0] v);
		logic signed [W-1:0] r;
		if (v[W] != v[W-1])
			r = v[W] ? WMIN : WMAX;
		else
			r = v[W-1:0];
		return r;
	endfunction

	function automatic logic [W-1:0] mag_w(input logic signed [W-1:0] v);
		logic [W-1:0] r;
		r = v[W-1] ? (~v + 1'b1) : v;
		return r;
	endfunction

endpackage

### rtl/core/linear_trapezoid_trajectory.sv
// Straight-line 3D move generator with a trapezoidal speed profile, Q16.16.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) loads the start and
// finish points and the speed and acceleration limits; cfg_ready is always high,
// write it only while the block is idle.
// Input channel (in_valid/in_stall) carries one word: func and dt. Start latches
// the registers and plans the move, step advances the move clock by dt,
// cancel jumps to the end. Every word yields one result word on the output
// channel (out_valid/out_stall): position, done_res, active, elapsed,
// total_time and progress.
// One word is worked on at a time; in_stall stays high until its result has
// been loaded into the output register. A step, cancel or spare word passes
// through the shared divider that forms the progress before it is loaded. A
// start first takes a square root for the length and then six divisions
// (direction, accel time, cruise or peak time, progress), only the progress one
// on a degenerate move, plus a second square root on short moves.
// A stalled result holds in the output register; the next word may be worked
// on meanwhile and waits at its end until the register is free.
// Reset zeroes config and move state, not running; work and output registers are not reset.
module linear_trapezoid_trajectory (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ltt_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ltt_pkg::W-1:0]               cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          func,
	input  logic signed [ltt_pkg::W-1:0]        dt,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [ltt_pkg::W-1:0]        pos_x,
	output logic signed [ltt_pkg::W-1:0]        pos_y,
	output logic signed [ltt_pkg::W-1:0]        pos_z,
	output logic                                done_res,
	output logic                                active,
	output logic [ltt_pkg::W-2:0]               elapsed,
	output logic [ltt_pkg::W-2:0]               total_time,
	output logic [16:0]                         progress
);
	import ltt_pkg::*;

	ltt_cmd_t cmd;
	ltt_sts_t sts;

	// registers take every write; config must only change while idle, the block does not enforce it
	assign cfg_ready = 1'b1;

	// sequencer: one datapath operation per cycle, waits on the shared units and on a stalled output
	ltt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// move state, shared multiplier, divider, square root and output register
	ltt_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.dt         (dt),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.done_res   (done_res),
		.active     (active),
		.elapsed    (elapsed),
		.total_time (total_time),
		.progress   (progress)
	);

`ifndef SYNTHESIS
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (active != done_res))
		else $error("active and done_res not complementary");

	a_prog: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (progress <= PROG_ONE))
		else $error("progress beyond full");

	a_clock: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (elapsed <= total_time))
		else $error("elapsed beyond total time");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("word accepted without entering work");
`endif

endmodule

### rtl/core/ltt_div.sv
module ltt_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ltt_pkg::W-1:0]         num,
	input  logic [ltt_pkg::W-1:0]         den,
	input  logic                          neg,
	output logic                          busy,
	output logic signed [ltt_pkg::W-1:0]  quo
);
	import ltt_pkg::*;

	localparam int STEPS = W + F;
	localparam int CW = $clog2(STEPS + 1);

	logic [STEPS-1:0] n_q;
	logic [W-1:0]     r_q;
	logic [W-1:0]     den_q;
	logic             neg_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic [W:0]       r_sh;
	logic             ge;
	logic [W:0]       r_sub;

	assign r_sh  = {r_q, n_q[STEPS-1]};
	assign ge    = r_sh >= {1'b0, den_q};
	assign r_sub = r_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(STEPS);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= (cnt_q != CW'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= {num, {F{1'b0}}};
			r_q   <= '0;
			den_q <= den;
			neg_q <= neg;
		end else if (busy_q) begin
			r_q <= ge ? r_sub[W-1:0] : r_sh[W-1:0];
			n_q <= {n_q[STEPS-2:0], ge};
		end
	end

	// saturate the quotient into the signed word
	always_comb begin
		if (den_q == '0)
			quo = neg_q ? WMIN : WMAX;
		else if (neg_q)
			quo = (n_q > {{(STEPS-W){1'b0}}, WMIN}) ? WMIN
				: W'(-$signed({1'b0, n_q}));
		else
			quo = (|n_q[STEPS-1:W-1]) ? WMAX : {1'b0, n_q[W-2:0]};
	end

	assign busy = busy_q;

endmodule

### rtl/core/ltt_sqrt.sv
module ltt_sqrt (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [2*ltt_pkg::W+1:0]  rad,
	output logic                     busy,
	output logic [ltt_pkg::W:0]      root
);
	import ltt_pkg::*;

	localparam int RW = 2 * W + 2;
	localparam int QW = W + 1;
	localparam int CW = $clog2(QW + 1);

	logic [RW-1:0] x_q;
	logic [QW:0]   r_q;
	logic [QW-1:0] q_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [QW+2:0] r_sh;
	logic [QW+2:0] t;
	logic          ge;
	logic [QW+2:0] r_sub;

	assign r_sh  = {r_q, x_q[RW-1:RW-2]};
	assign t     = {1'b0, q_q, 2'b01};
	assign ge    = r_sh >= t;
	assign r_sub = r_sh - t;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(QW);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= (cnt_q != CW'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= rad;
			r_q <= '0;
			q_q <= '0;
		end else if (busy_q) begin
			x_q <= {x_q[RW-3:0], 2'b00};
			r_q <= ge ? r_sub[QW:0] : r_sh[QW:0];
			q_q <= {q_q[QW-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign root = q_q;

endmodule

### rtl/core/ltt_dp.sv
module ltt_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ltt_pkg::ltt_cmd_t                   cmd,
	output ltt_pkg::ltt_sts_t                   sts,
	input  logic                                cfg_we,
	input  logic [ltt_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ltt_pkg::W-1:0]               cfg_data,
	input  logic signed [ltt_pkg::W-1:0]        dt,
	output logic signed [ltt_pkg::W-1:0]        pos_x,
	output logic signed [ltt_pkg::W-1:0]        pos_y,
	output logic signed [ltt_pkg::W-1:0]        pos_z,
	output logic                                done_res,
	output logic                                active,
	output logic [ltt_pkg::W-2:0]               elapsed,
	output logic [ltt_pkg::W-2:0]               total_time,
	output logic [16:0]                         progress
);
	import ltt_pkg::*;

	typedef enum logic [2:0] {SEG_ZERO, SEG_ACC, SEG_CRU, SEG_DEC, SEG_FULL} seg_t;

	logic [W-1:0]        cfg_q [CFG_N];
	logic signed [W-1:0] org_q [3];
	logic signed [W-1:0] tgt_q [3];
	logic signed [W-1:0] dir_q [3];
	logic signed [W-1:0] pos_q [3];
	logic [W-2:0]        len_q, spd_q, acc_q, at_q, ct_q, mt_q, clk_q;
	logic [W-3:0]        da_q;
	logic                run_q, at_tgt_q, neg_q;
	logic signed [W-1:0] dt_q, s_q;
	logic [2*W+1:0]      sum_q;
	logic [2*W-1:0]      prod_q;
	logic [16:0]         prog_q;

	logic signed [W:0]   dv [3];
	logic [W-1:0]        dmag [3];
	logic [W-1:0]        mul_a, mul_b;
	logic [2*W-1:0]      mul_p;
	logic                mul_en;
	logic [W-2:0]        mqp;
	seg_t                seg;
	logic [W-2:0]        x_seg;
	logic [W:0]          cruise_end;

	logic                div_start, div_neg, div_busy;
	logic [W-1:0]        div_num, div_den;
	logic signed [W-1:0] div_quo;
	logic                sqrt_start, sqrt_busy;
	logic [2*W+1:0]      sqrt_rad;
	logic [W:0]          root;

	logic signed [W-1:0] dt_eff;
	logic [W:0]          csum;
	logic [W-2:0]        c_sat, c_new;
	logic [W:0]          mt_sum;
	logic [W-1:0]        s_dec;
	logic [W-1:0]        m_lo;
	logic [2*W-F-1:0]    m48;
	logic signed [W:0]   pv;
	logic [W-2:0]        len_less;

	ltt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.neg    (div_neg),
		.busy   (div_busy),
		.quo    (div_quo)
	);

	ltt_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.rad    (sqrt_rad),
		.busy   (sqrt_busy),
		.root   (root)
	);

	for (genvar i = 0; i < 3; i++) begin : g_axis
		logic [W:0] dneg;
		assign dv[i]   = {tgt_q[i][W-1], tgt_q[i]} - {org_q[i][W-1], org_q[i]};
		assign dneg    = -dv[i];
		assign dmag[i] = dv[i][W] ? dneg[W-1:0] : dv[i][W-1:0];
	end

	assign mqp = mq_sat(prod_q);

	// which piece of the profile the move clock sits in
	assign cruise_end = {2'b00, at_q} + {2'b00, ct_q};
	always_comb begin
		if (len_q == '0 || mt_q == '0 || clk_q == '0)
			seg = SEG_ZERO;
		else if (clk_q < at_q)
			seg = SEG_ACC;
		else if ({2'b00, clk_q} < cruise_end)
			seg = SEG_CRU;
		else if (clk_q < mt_q)
			seg = SEG_DEC;
		else
			seg = SEG_FULL;
	end

	always_comb begin
		unique case (seg)
			SEG_ACC: x_seg = clk_q;
			SEG_CRU: x_seg = at_q;
			SEG_DEC: x_seg = mt_q - clk_q;
			default: x_seg = '0;
		endcase
	end

	// shared multiplier operand select
	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_en = 1'b1;
		unique case (cmd.op)
			OP_SQ: begin
				mul_a = dmag[cmd.axis];
				mul_b = dmag[cmd.axis];
			end
			OP_M_A_TA: begin
				mul_a = {1'b0, acc_q};
				mul_b = {1'b0, at_q};
			end
			OP_M_P_TA: begin
				mul_a = {1'b0, mqp};
				mul_b = {1'b0, at_q};
			end
			OP_M_A_L: begin
				mul_a = {1'b0, acc_q};
				mul_b = {1'b0, len_q};
			end
			OP_S1: begin
				mul_a = {1'b0, acc_q};
				mul_b = {1'b0, x_seg};
			end
			OP_S2: begin
				mul_a = {1'b0, mqp};
				mul_b = {1'b0, x_seg};
			end
			OP_S4: begin
				mul_a = {1'b0, spd_q};
				mul_b = {1'b0, clk_q - at_q};
			end
			OP_P1: begin
				mul_a = mag_w(dir_q[cmd.axis]);
				mul_b = mag_w(s_q);
			end
			default: mul_en = 1'b0;
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// divider operand select
	assign len_less = len_q - {da_q, 1'b0};
	always_comb begin
		div_start = 1'b1;
		div_num   = '0;
		div_den   = '0;
		div_neg   = 1'b0;
		unique case (cmd.op)
			OP_DIV_DIR: begin
				div_num = dmag[cmd.axis];
				div_den = {1'b0, len_q};
				div_neg = dv[cmd.axis][W];
			end
			OP_DIV_TA: begin
				div_num = {1'b0, spd_q};
				div_den = {1'b0, acc_q};
			end
			OP_DIV_CT: begin
				div_num = {1'b0, len_less};
				div_den = {1'b0, spd_q};
			end
			OP_DIV_AT: begin
				div_num = {1'b0, (|root[W:W-1]) ? WMAX31 : root[W-2:0]};
				div_den = {1'b0, acc_q};
			end
			OP_DIV_PR: begin
				if (s_q[W-1])
					div_num = '0;
				else if (s_q > $signed({1'b0, len_q}))
					div_num = {1'b0, len_q};
				else
					div_num = s_q;
				div_den = {1'b0, len_q};
			end
			default: div_start = 1'b0;
		endcase
	end

	assign sqrt_start = (cmd.op == OP_SQRT_SUM) || (cmd.op == OP_SQRT_VP);
	assign sqrt_rad   = (cmd.op == OP_SQRT_VP) ? {2'b00, prod_q} : sum_q;

	// time step: minimum step for non-positive dt, saturate, clamp at the end
	assign dt_eff = (dt_q[W-1] || dt_q == '0) ? W'(DT_MIN) : dt_q;
	assign csum   = {2'b00, clk_q} + {1'b0, dt_eff};
	assign c_sat  = (|csum[W:W-1]) ? WMAX31 : csum[W-2:0];
	assign c_new  = (c_sat > mt_q) ? mt_q : c_sat;
	assign mt_sum = {1'b0, at_q, 1'b0} + {2'b00, ct_q};
	assign s_dec  = {1'b0, len_q} - {2'b00, mqp[W-2:1]};

	// signed product back to word scale
	assign m48  = prod_q[2*W-1:F];
	assign m_lo = (m48 > {{(W-F){1'b0}}, WMIN}) ? WMIN : m48[W-1:0];
	always_comb begin
		if (neg_q)
			pv = -$signed({1'b0, m_lo});
		else
			pv = (|m48[2*W-F-1:W-1]) ? {1'b0, WMAX} : {2'b00, m48[W-2:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CFG_N; i++)
				cfg_q[i] <= '0;
			for (int i = 0; i < 3; i++) begin
				org_q[i] <= '0;
				tgt_q[i] <= '0;
				dir_q[i] <= '0;
			end
			len_q    <= '0;
			spd_q    <= '0;
			acc_q    <= '0;
			at_q     <= '0;
			ct_q     <= '0;
			mt_q     <= '0;
			clk_q    <= '0;
			run_q    <= 1'b0;
			at_tgt_q <= 1'b0;
		end else begin
			if (cfg_we)
				cfg_q[cfg_index] <= cfg_data;
			unique case (cmd.op)
				OP_LATCH: begin
					org_q[0] <= cfg_q[REG_START_X];
					org_q[1] <= cfg_q[REG_START_Y];
					org_q[2] <= cfg_q[REG_START_Z];
					tgt_q[0] <= cfg_q[REG_FINISH_X];
					tgt_q[1] <= cfg_q[REG_FINISH_Y];
					tgt_q[2] <= cfg_q[REG_FINISH_Z];
					spd_q    <= cfg_q[REG_SPEED][W-2:0];
					acc_q    <= cfg_q[REG_ACCEL][W-2:0];
					clk_q    <= '0;
					at_tgt_q <= 1'b0;
				end
				OP_LEN:  len_q <= (|root[W:W-1]) ? WMAX31 : root[W-2:0];
				OP_ZERO: begin
					for (int i = 0; i < 3; i++)
						dir_q[i] <= '0;
					at_q  <= '0;
					ct_q  <= '0;
					mt_q  <= '0;
					run_q <= 1'b0;
				end
				OP_DIR: dir_q[cmd.axis] <= div_quo;
				OP_TA:  at_q <= div_quo[W-2:0];
				OP_CT:  ct_q <= div_quo[W-2:0];
				OP_AT: begin
					at_q <= div_quo[W-2:0];
					ct_q <= '0;
				end
				OP_MT: begin
					mt_q  <= (|mt_sum[W:W-1]) ? WMAX31 : mt_sum[W-2:0];
					run_q <= 1'b1;
				end
				OP_STEP: begin
					at_tgt_q <= !run_q;
					if (run_q) begin
						clk_q <= c_new;
						run_q <= !(({2'b00, c_new} + (W+1)'(EPS_T)) >= {2'b00, mt_q});
					end
				end
				OP_CANCEL: begin
					clk_q    <= mt_q;
					run_q    <= 1'b0;
					at_tgt_q <= 1'b0;
				end
				OP_SPARE: at_tgt_q <= 1'b0;
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (mul_en)
			prod_q <= mul_p;
		unique case (cmd.op)
			OP_LATCH: sum_q <= '0;
			OP_SUM:   sum_q <= sum_q + {2'b00, prod_q};
			OP_DA:    da_q <= mqp[W-2:1];
			OP_S3: begin
				unique case (seg)
					SEG_ACC, SEG_CRU: s_q <= {2'b00, mqp[W-2:1]};
					SEG_DEC:          s_q <= s_dec;
					SEG_FULL:         s_q <= {1'b0, len_q};
					default:          s_q <= '0;
				endcase
			end
			OP_S5: if (seg == SEG_CRU) s_q <= sat_w({s_q[W-1], s_q} + {2'b00, mqp});
			OP_P1: neg_q <= dir_q[cmd.axis][W-1] ^ s_q[W-1];
			OP_P2: pos_q[cmd.axis] <= at_tgt_q ? tgt_q[cmd.axis]
				: sat_w({org_q[cmd.axis][W-1], org_q[cmd.axis]} + pv);
			OP_PR: begin
				if (len_q == '0)
					prog_q <= PROG_ONE;
				else if (div_quo > $signed({{(W-17){1'b0}}, PROG_ONE}))
					prog_q <= PROG_ONE;
				else
					prog_q <= div_quo[16:0];
			end
			OP_EMIT: begin
				pos_x      <= pos_q[0];
				pos_y      <= pos_q[1];
				pos_z      <= pos_q[2];
				done_res   <= !run_q;
				active     <= run_q;
				elapsed    <= clk_q;
				total_time <= mt_q;
				progress   <= prog_q;
			end
			default: ;
		endcase
		if (cmd.take)
			dt_q <= dt;
	end

	assign sts.div_busy   = div_busy;
	assign sts.sqrt_busy  = sqrt_busy;
	assign sts.degen      = (len_q == '0) || (spd_q == '0) || (acc_q == '0);
	assign sts.short_move = {da_q, 1'b0} > len_q;

endmodule

### rtl/core/ltt_ctrl.sv
module ltt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         func,
	output logic               out_valid,
	input  logic               out_stall,
	input  ltt_pkg::ltt_sts_t  sts,
	output ltt_pkg::ltt_cmd_t  cmd
);
	import ltt_pkg::*;

	ctrl_state_t state_q, state_d;
	logic [1:0]  axis_q, axis_d;
	logic        out_valid_q;
	logic        can_emit;

	assign can_emit = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		axis_d  = axis_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) begin
				unique case (func_t'(func))
					FUNC_START:  state_d = ST_LATCH;
					FUNC_STEP:   state_d = ST_STEP;
					FUNC_CANCEL: state_d = ST_CANCEL;
					FUNC_SPARE:  state_d = ST_SPARE;
				endcase
			end
			ST_LATCH: begin
				axis_d  = '0;
				state_d = ST_SQ;
			end
			ST_SQ: state_d = ST_SUM;
			ST_SUM: begin
				if (axis_q == 2'd2) begin
					axis_d  = '0;
					state_d = ST_SQRT_GO;
				end else begin
					axis_d  = axis_q + 1'b1;
					state_d = ST_SQ;
				end
			end
			ST_SQRT_GO:   state_d = ST_SQRT_WAIT;
			ST_SQRT_WAIT: if (!sts.sqrt_busy) state_d = ST_CHECK;
			ST_CHECK: begin
				axis_d  = '0;
				state_d = sts.degen ? ST_ZERO : ST_DIR_GO;
			end
			ST_ZERO:   state_d = ST_S1;
			ST_DIR_GO: state_d = ST_DIR_WAIT;
			ST_DIR_WAIT: if (!sts.div_busy) begin
				if (axis_q == 2'd2) begin
					axis_d  = '0;
					state_d = ST_TA_GO;
				end else begin
					axis_d  = axis_q + 1'b1;
					state_d = ST_DIR_GO;
				end
			end
			ST_TA_GO:   state_d = ST_TA_WAIT;
			ST_TA_WAIT: if (!sts.div_busy) state_d = ST_DA_M1;
			ST_DA_M1:   state_d = ST_DA_M2;
			ST_DA_M2:   state_d = ST_DA_PUT;
			ST_DA_PUT:  state_d = ST_DECIDE;
			ST_DECIDE:  state_d = sts.short_move ? ST_VP_MUL : ST_CT_GO;
			ST_CT_GO:   state_d = ST_CT_WAIT;
			ST_CT_WAIT: if (!sts.div_busy) state_d = ST_MT;
			ST_MT:      state_d = ST_S1;
			ST_VP_MUL:  state_d = ST_VP_GO;
			ST_VP_GO:   state_d = ST_VP_WAIT;
			ST_VP_WAIT: if (!sts.sqrt_busy) state_d = ST_AT_GO;
			ST_AT_GO:   state_d = ST_AT_WAIT;
			ST_AT_WAIT: if (!sts.div_busy) state_d = ST_MT;
			ST_STEP, ST_CANCEL, ST_SPARE: state_d = ST_S1;
			ST_S1: state_d = ST_S2;
			ST_S2: state_d = ST_S3;
			ST_S3: state_d = ST_S4;
			ST_S4: state_d = ST_S5;
			ST_S5: begin
				axis_d  = '0;
				state_d = ST_P1;
			end
			ST_P1: state_d = ST_P2;
			ST_P2: begin
				if (axis_q == 2'd2) begin
					axis_d  = '0;
					state_d = ST_PR_GO;
				end else begin
					axis_d  = axis_q + 1'b1;
					state_d = ST_P1;
				end
			end
			ST_PR_GO:   state_d = ST_PR_WAIT;
			ST_PR_WAIT: if (!sts.div_busy) state_d = ST_EMIT;
			ST_EMIT:    if (can_emit) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.axis = axis_q;
		cmd.take = (state_q == ST_IDLE) && in_valid;
		unique case (state_q)
			ST_LATCH:     cmd.op = OP_LATCH;
			ST_SQ:        cmd.op = OP_SQ;
			ST_SUM:       cmd.op = OP_SUM;
			ST_SQRT_GO:   cmd.op = OP_SQRT_SUM;
			ST_SQRT_WAIT: cmd.op = sts.sqrt_busy ? OP_NONE : OP_LEN;
			ST_ZERO:      cmd.op = OP_ZERO;
			ST_DIR_GO:    cmd.op = OP_DIV_DIR;
			ST_DIR_WAIT:  cmd.op = sts.div_busy ? OP_NONE : OP_DIR;
			ST_TA_GO:     cmd.op = OP_DIV_TA;
			ST_TA_WAIT:   cmd.op = sts.div_busy ? OP_NONE : OP_TA;
			ST_DA_M1:     cmd.op = OP_M_A_TA;
			ST_DA_M2:     cmd.op = OP_M_P_TA;
			ST_DA_PUT:    cmd.op = OP_DA;
			ST_CT_GO:     cmd.op = OP_DIV_CT;
			ST_CT_WAIT:   cmd.op = sts.div_busy ? OP_NONE : OP_CT;
			ST_MT:        cmd.op = OP_MT;
			ST_VP_MUL:    cmd.op = OP_M_A_L;
			ST_VP_GO:     cmd.op = OP_SQRT_VP;
			ST_AT_GO:     cmd.op = OP_DIV_AT;
			ST_AT_WAIT:   cmd.op = sts.div_busy ? OP_NONE : OP_AT;
			ST_STEP:      cmd.op = OP_STEP;
			ST_CANCEL:    cmd.op = OP_CANCEL;
			ST_SPARE:     cmd.op = OP_SPARE;
			ST_S1:        cmd.op = OP_S1;
			ST_S2:        cmd.op = OP_S2;
			ST_S3:        cmd.op = OP_S3;
			ST_S4:        cmd.op = OP_S4;
			ST_S5:        cmd.op = OP_S5;
			ST_P1:        cmd.op = OP_P1;
			ST_P2:        cmd.op = OP_P2;
			ST_PR_GO:     cmd.op = OP_DIV_PR;
			ST_PR_WAIT:   cmd.op = sts.div_busy ? OP_NONE : OP_PR;
			ST_EMIT:      cmd.op = can_emit ? OP_EMIT : OP_NONE;
			default:      cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			axis_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			axis_q  <= axis_d;
			if (state_q == ST_EMIT && can_emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule
